// ===== src/spc_pkg.sv =====
package spc_pkg;

  // Shape pair codes carried in the kind field.
  localparam logic [1:0] KIND_CC   = 2'd0;  // circle A against circle B
  localparam logic [1:0] KIND_CB   = 2'd1;  // circle A against box B
  localparam logic [1:0] KIND_BB   = 2'd2;  // box A against box B
  localparam logic [1:0] KIND_NONE = 2'd3;  // unused, never a hit

  // Square root: the radicand is a squared distance in Q.18 scaled up by 2^16.
  localparam int ROOT_W = 31;
  localparam int RAD_W  = 2 * ROOT_W;

  // Normal divider: numerator is a Q.9 magnitude shifted up by 22 plus a
  // rounding half of the divisor, the quotient is a Q1.14 magnitude.
  localparam int NUM_W = 45;
  localparam int QUO_W = 15;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [23:0]  ax;
    logic signed [23:0]  ay;
    logic [19:0]         a_radius;
    logic [19:0]         a_width;
    logic [19:0]         a_height;
    logic signed [23:0]  bx;
    logic signed [23:0]  by;
    logic [19:0]         b_radius;
    logic [19:0]         b_width;
    logic [19:0]         b_height;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic signed [15:0]  normal_x;
    logic signed [15:0]  normal_y;
    logic [21:0]         penetration;
  } rsp_t;

endpackage

// ===== src/spc_sqrt.sv =====
module spc_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [spc_pkg::RAD_W-1:0]  rad,
  output logic [spc_pkg::ROOT_W-1:0] root
);

  localparam int RADW  = spc_pkg::RAD_W;
  localparam int ROOTW = spc_pkg::ROOT_W;
  localparam int RMW   = ROOTW + 3;

  // One result bit per stage, two radicand bits consumed per stage.
  logic [RMW-1:0]   rem_q  [ROOTW];
  logic [ROOTW-1:0] root_q [ROOTW];
  logic [RADW-1:0]  rad_q  [ROOTW];

  for (genvar k = 0; k < ROOTW; k++) begin : g_stage
    logic [RMW-1:0]   rem_src;
    logic [RMW-1:0]   rem_sh;
    logic [RMW-1:0]   trial;
    logic [ROOTW-1:0] root_src;
    logic [RADW-1:0]  rad_src;

    if (k == 0) begin : g_first
      assign rem_src  = '0;
      assign root_src = '0;
      assign rad_src  = rad;
    end else begin : g_rest
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign rad_src  = rad_q[k-1];
    end

    assign rem_sh = {rem_src[RMW-3:0], rad_src[RADW-1 -: 2]};
    assign trial  = RMW'({root_src, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_src[ROOTW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_src[ROOTW-2:0], 1'b0};
        end
        rad_q[k] <= {rad_src[RADW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[ROOTW-1];

endmodule

// ===== src/spc_div.sv =====
module spc_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [spc_pkg::NUM_W-1:0]  num,
  input  logic [spc_pkg::ROOT_W-1:0] den,
  output logic [spc_pkg::QUO_W-1:0]  quo
);

  localparam int NUMW = spc_pkg::NUM_W;
  localparam int DENW = spc_pkg::ROOT_W;
  localparam int QW   = spc_pkg::QUO_W;

  // Restoring division, one quotient bit per stage, most significant first.
  // The quotient is known to stay below 2^QW.
  logic [NUMW-1:0] rem_q [QW];
  logic [DENW-1:0] den_q [QW];
  logic [QW-1:0]   quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [NUMW-1:0] rem_src;
    logic [NUMW-1:0] cmp;
    logic [DENW-1:0] den_src;
    logic [QW-1:0]   quo_src;

    if (k == 0) begin : g_first
      assign rem_src = num;
      assign den_src = den;
      assign quo_src = '0;
    end else begin : g_rest
      assign rem_src = rem_q[k-1];
      assign den_src = den_q[k-1];
      assign quo_src = quo_q[k-1];
    end

    assign cmp = NUMW'(den_src) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_src >= cmp) begin
          rem_q[k] <= rem_src - cmp;
          quo_q[k] <= {quo_src[QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem_src;
          quo_q[k] <= {quo_src[QW-2:0], 1'b0};
        end
        den_q[k] <= den_src;
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== src/shape_pair_contact_top.sv =====
// Pipeline: 54 register stages, the depth being set by the 31-stage square root and
// 15-stage divider.
// Throughput: one request per clock cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output.
// Reset: synchronous rst clears the stage valid bits only; the datapath is not reset.
module shape_pair_contact_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  spc_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output spc_pkg::rsp_t   rsp
);

  // Geometry is carried in Q.9: positions are doubled, and full sizes read
  // as Q.9 are half sizes.
  localparam int CW     = 28;                // signed coordinate width
  localparam int RW     = 22;                // radius and near-distance width
  localparam int HW     = RW - 1;            // half-size sums
  localparam int SQ_W   = 2 * RW;            // one square
  localparam int D2_W   = SQ_W + 1;          // sum of two squares
  localparam int NRM_W  = 16;
  localparam int PEN_W  = 22;
  localparam int ROOT_W = spc_pkg::ROOT_W;
  localparam int RAD_W  = spc_pkg::RAD_W;
  localparam int NUM_W  = spc_pkg::NUM_W;
  localparam int QUO_W  = spc_pkg::QUO_W;
  localparam int PR_W   = ROOT_W + 1;

  // The distance comes out of the root in Q.17; the radius is moved there by
  // shifting up 8 and the difference comes back to Q.8 by rounding off 9 bits.
  localparam int D2_SHIFT    = 16;
  localparam int R_SHIFT     = 8;
  localparam int DIST_SHIFT  = 9;
  localparam int ROUND_HALF  = 256;
  localparam int NRM_SHIFT   = 22;

  localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

  // Stage bookkeeping: five front stages, then the side line that runs next
  // to the square root, one stage that forms the divider operands, and the
  // divider, then the output register.
  localparam int FRONT    = 5;
  localparam int POST_IDX = ROOT_W + 1;
  localparam int SIDE_LEN = POST_IDX + 1 + QUO_W;
  localparam int PIPE_LEN = FRONT + SIDE_LEN + 1;

  typedef enum logic [1:0] {
    FACE_LEFT,
    FACE_RIGHT,
    FACE_BOTTOM,
    FACE_TOP
  } face_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] xmin;
    logic signed [CW-1:0] xmax;
    logic signed [CW-1:0] ymin;
    logic signed [CW-1:0] ymax;
    logic signed [CW-1:0] dxq;
    logic signed [CW-1:0] dyq;
    logic [RW-1:0]       r;
    logic [HW-1:0]       ar2;
    logic [HW-1:0]       sumw;
    logic [HW-1:0]       sumh;
  } s2_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [RW-1:0]       r;
    logic                in_box;
    logic [3:0][RW-1:0]  ov;
    logic [HW-1:0]       ar2;
    logic [CW-1:0]       adx;
    logic [CW-1:0]       ady;
    logic [HW-1:0]       sumw;
    logic [HW-1:0]       sumh;
    logic                px_lt;
    logic                py_lt;
  } s3_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [RW-1:0]       ux;
    logic [RW-1:0]       uy;
    logic                far;
    logic                dx_neg;
    logic                dy_neg;
    logic [RW-1:0]       r;
    logic                in_box;
    logic [RW-1:0]       m01;
    logic [RW-1:0]       m23;
    logic                sel01;
    logic                sel23;
    logic [HW-1:0]       ar2;
    logic signed [CW-1:0] xo;
    logic signed [CW-1:0] yo;
    logic                px_lt;
    logic                py_lt;
  } s4_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SQ_W-1:0]     sqx;
    logic [SQ_W-1:0]     sqy;
    logic [SQ_W-1:0]     rr;
    logic                far;
    logic                dx_neg;
    logic                dy_neg;
    logic [RW-1:0]       ux;
    logic [RW-1:0]       uy;
    logic [RW-1:0]       r;
    logic                in_box;
    logic [RW-1:0]       best;
    face_t               face;
    logic [HW-1:0]       ar2;
    logic                box_hit;
    logic                box_use_x;
    logic [RW-1:0]       box_depth;
    logic                px_lt;
    logic                py_lt;
  } s5_t;

  typedef struct packed {
    logic                 hit;
    logic                 use_root;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic [PEN_W-1:0]     pen;
    logic [RW-1:0]        ux;
    logic [RW-1:0]        uy;
    logic [RW-1:0]        r;
  } side_t;

  // Flow control: every stage moves when the output register is free or
  // being emptied. Valid bits ride along with the data.
  logic                en;
  logic [PIPE_LEN-1:0] vld;

  assign en        = !vld[PIPE_LEN-1] || rsp_ready;
  assign req_ready = en;
  assign rsp_valid = vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], req_valid};
    end
  end

  // Stage 1: the request is registered as it arrives.
  spc_pkg::req_t s1_req;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_req <= req;
    end
  end

  // Stage 2: move to Q.9, build the extent of box B and the center offsets.
  s2_t s2, s2_next;
  logic signed [CW-1:0] qx2, qy2, bw2, bh2;

  assign qx2 = CW'($signed({s1_req.bx, 1'b0}));
  assign qy2 = CW'($signed({s1_req.by, 1'b0}));
  assign bw2 = $signed(CW'(s1_req.b_width));
  assign bh2 = $signed(CW'(s1_req.b_height));

  always_comb begin
    s2_next.kind = s1_req.kind;
    s2_next.px   = CW'($signed({s1_req.ax, 1'b0}));
    s2_next.py   = CW'($signed({s1_req.ay, 1'b0}));
    s2_next.xmin = qx2 - bw2;
    s2_next.xmax = qx2 + bw2;
    s2_next.ymin = qy2 - bh2;
    s2_next.ymax = qy2 + bh2;
    s2_next.dxq  = qx2 - s2_next.px;
    s2_next.dyq  = qy2 - s2_next.py;
    // Circle pairs use the sum of both radii, circle against box the one.
    if (s1_req.kind == spc_pkg::KIND_CC) begin
      s2_next.r = {HW'(s1_req.a_radius) + HW'(s1_req.b_radius), 1'b0};
    end else begin
      s2_next.r = {1'b0, s1_req.a_radius, 1'b0};
    end
    s2_next.ar2  = {s1_req.a_radius, 1'b0};
    s2_next.sumw = HW'(s1_req.a_width) + HW'(s1_req.b_width);
    s2_next.sumh = HW'(s1_req.a_height) + HW'(s1_req.b_height);
  end

  // Stage 3: clamp the circle center to the box, face distances, and the
  // absolute center offsets for the box pair.
  s3_t  s3, s3_next;
  logic lo_x, hi_x, lo_y, hi_y;
  logic signed [CW-1:0] cdx, cdy;

  always_comb begin
    lo_x = s2.px < s2.xmin;
    hi_x = s2.px > s2.xmax;
    lo_y = s2.py < s2.ymin;
    hi_y = s2.py > s2.ymax;
    cdx  = lo_x ? s2.xmin - s2.px : (hi_x ? s2.xmax - s2.px : '0);
    cdy  = lo_y ? s2.ymin - s2.py : (hi_y ? s2.ymax - s2.py : '0);

    s3_next.kind   = s2.kind;
    s3_next.dx     = (s2.kind == spc_pkg::KIND_CC) ? s2.dxq : cdx;
    s3_next.dy     = (s2.kind == spc_pkg::KIND_CC) ? s2.dyq : cdy;
    s3_next.r      = s2.r;
    s3_next.in_box = !lo_x && !hi_x && !lo_y && !hi_y;
    s3_next.ov[0]  = RW'(s2.px - s2.xmin);
    s3_next.ov[1]  = RW'(s2.xmax - s2.px);
    s3_next.ov[2]  = RW'(s2.py - s2.ymin);
    s3_next.ov[3]  = RW'(s2.ymax - s2.py);
    s3_next.ar2    = s2.ar2;
    s3_next.adx    = s2.dxq[CW-1] ? -s2.dxq : s2.dxq;
    s3_next.ady    = s2.dyq[CW-1] ? -s2.dyq : s2.dyq;
    s3_next.sumw   = s2.sumw;
    s3_next.sumh   = s2.sumh;
    s3_next.px_lt  = s2.dxq > 0;
    s3_next.py_lt  = s2.dyq > 0;
  end

  // Stage 4: magnitudes and an early reject when either offset alone
  // exceeds the radius, box overlaps, and the first round of the face minimum.
  s4_t s4, s4_next;
  logic [CW-1:0] ux_full, uy_full;

  always_comb begin
    ux_full = s3.dx[CW-1] ? -s3.dx : s3.dx;
    uy_full = s3.dy[CW-1] ? -s3.dy : s3.dy;

    s4_next.kind   = s3.kind;
    s4_next.ux     = RW'(ux_full);
    s4_next.uy     = RW'(uy_full);
    s4_next.far    = (ux_full > CW'(s3.r)) || (uy_full > CW'(s3.r));
    s4_next.dx_neg = s3.dx[CW-1];
    s4_next.dy_neg = s3.dy[CW-1];
    s4_next.r      = s3.r;
    s4_next.in_box = s3.in_box;
    // Ties keep the earlier face.
    s4_next.sel01  = s3.ov[1] < s3.ov[0];
    s4_next.sel23  = s3.ov[3] < s3.ov[2];
    s4_next.m01    = s4_next.sel01 ? s3.ov[1] : s3.ov[0];
    s4_next.m23    = s4_next.sel23 ? s3.ov[3] : s3.ov[2];
    s4_next.ar2    = s3.ar2;
    s4_next.xo     = $signed(CW'(s3.sumw)) - $signed(s3.adx);
    s4_next.yo     = $signed(CW'(s3.sumh)) - $signed(s3.ady);
    s4_next.px_lt  = s3.px_lt;
    s4_next.py_lt  = s3.py_lt;
  end

  // Stage 5: the squares, the nearest face, and the box pair decision.
  s5_t  s5, s5_next;
  logic pick23;

  always_comb begin
    pick23 = s4.m23 < s4.m01;

    s5_next.kind      = s4.kind;
    s5_next.sqx       = s4.ux * s4.ux;
    s5_next.sqy       = s4.uy * s4.uy;
    s5_next.rr        = s4.r * s4.r;
    s5_next.far       = s4.far;
    s5_next.dx_neg    = s4.dx_neg;
    s5_next.dy_neg    = s4.dy_neg;
    s5_next.ux        = s4.ux;
    s5_next.uy        = s4.uy;
    s5_next.r         = s4.r;
    s5_next.in_box    = s4.in_box;
    s5_next.best      = pick23 ? s4.m23 : s4.m01;
    if (pick23) begin
      s5_next.face = s4.sel23 ? FACE_TOP : FACE_BOTTOM;
    end else begin
      s5_next.face = s4.sel01 ? FACE_RIGHT : FACE_LEFT;
    end
    s5_next.ar2       = s4.ar2;
    s5_next.box_hit   = (s4.xo >= 0) && (s4.yo >= 0);
    s5_next.box_use_x = s4.xo < s4.yo;
    s5_next.box_depth = RW'(s5_next.box_use_x ? s4.xo : s4.yo);
    s5_next.px_lt     = s4.px_lt;
    s5_next.py_lt     = s4.py_lt;
  end

  // Stage 6: squared distance, hit test, and every result that needs no
  // root. A round contact with distinct points is marked for the root path.
  side_t            side_next;
  logic [D2_W-1:0]  d2, d2_q;
  logic             rhit;
  logic             take_round;
  logic [RW:0]      half_r, half_face, half_box;

  always_comb begin
    d2         = D2_W'(s5.sqx) + D2_W'(s5.sqy);
    rhit       = !s5.far && (d2 <= D2_W'(s5.rr));
    take_round = (s5.kind == spc_pkg::KIND_CC) ||
                 ((s5.kind == spc_pkg::KIND_CB) && !s5.in_box);
    half_r     = (RW + 1)'(s5.r) + 1'b1;
    half_face  = (RW + 1)'(s5.best) + (RW + 1)'(s5.ar2) + 1'b1;
    half_box   = (RW + 1)'(s5.box_depth) + 1'b1;

    side_next          = '0;
    side_next.neg_x    = s5.dx_neg;
    side_next.neg_y    = s5.dy_neg;
    side_next.ux       = s5.ux;
    side_next.uy       = s5.uy;
    side_next.r        = s5.r;

    if (take_round) begin
      if (rhit) begin
        side_next.hit = 1'b1;
        // Coincident centers: no direction, depth is the whole radius.
        if (d2 == '0) begin
          side_next.pen = half_r[RW:1];
        end else begin
          side_next.use_root = 1'b1;
        end
      end
    end else if (s5.kind == spc_pkg::KIND_CB) begin
      // The circle center lies inside or on the box: push out through the
      // nearest face.
      side_next.hit = 1'b1;
      side_next.pen = half_face[RW:1];
      case (s5.face)
        FACE_LEFT:   side_next.nx = ONE_Q14;
        FACE_RIGHT:  side_next.nx = -ONE_Q14;
        FACE_BOTTOM: side_next.ny = ONE_Q14;
        default:     side_next.ny = -ONE_Q14;
      endcase
    end else if (s5.kind == spc_pkg::KIND_BB) begin
      if (s5.box_hit) begin
        side_next.hit = 1'b1;
        side_next.pen = half_box[RW:1];
        if (s5.box_use_x) begin
          side_next.nx = s5.px_lt ? ONE_Q14 : -ONE_Q14;
        end else begin
          side_next.ny = s5.py_lt ? ONE_Q14 : -ONE_Q14;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      d2_q <= d2;
    end
  end

  // Distance in Q.17 from the scaled squared distance.
  logic [ROOT_W-1:0] root;

  spc_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (RAD_W'({d2_q, {D2_SHIFT{1'b0}}})),
    .root (root)
  );

  // Side line: results decided up front travel next to the root and the
  // dividers. The stage after the root fills in the round penetration and
  // registers the divider operands.
  side_t             side_q [SIDE_LEN];
  side_t             post_side;
  logic [PR_W-1:0]   pen_tmp;
  logic [NUM_W-1:0]  num_x_q, num_y_q;
  logic [ROOT_W-1:0] den_q;

  always_comb begin
    post_side = side_q[POST_IDX-1];
    pen_tmp   = PR_W'({side_q[POST_IDX-1].r, {R_SHIFT{1'b0}}}) - PR_W'(root) +
                PR_W'(ROUND_HALF);
    if (side_q[POST_IDX-1].use_root) begin
      post_side.pen = pen_tmp[DIST_SHIFT +: PEN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_next;
      for (int k = 1; k < SIDE_LEN; k++) begin
        if (k == POST_IDX) begin
          side_q[k] <= post_side;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
      num_x_q <= (NUM_W'(side_q[POST_IDX-1].ux) << NRM_SHIFT) + NUM_W'(root >> 1);
      num_y_q <= (NUM_W'(side_q[POST_IDX-1].uy) << NRM_SHIFT) + NUM_W'(root >> 1);
      den_q   <= root;
    end
  end

  // Rounded normal components; the quotient never exceeds one in Q1.14.
  logic [QUO_W-1:0] quo_x, quo_y;

  spc_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (num_x_q),
    .den (den_q),
    .quo (quo_x)
  );

  spc_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (num_y_q),
    .den (den_q),
    .quo (quo_y)
  );

  // Output register: signs go back on the divided components.
  side_t                   last;
  logic signed [NRM_W-1:0] mag_x, mag_y;
  spc_pkg::rsp_t           rsp_next;

  always_comb begin
    last  = side_q[SIDE_LEN-1];
    mag_x = $signed(NRM_W'(quo_x));
    mag_y = $signed(NRM_W'(quo_y));
    rsp_next.hit         = last.hit;
    rsp_next.penetration = last.pen;
    if (last.use_root) begin
      rsp_next.normal_x = last.neg_x ? -mag_x : mag_x;
      rsp_next.normal_y = last.neg_y ? -mag_y : mag_y;
    end else begin
      rsp_next.normal_x = last.nx;
      rsp_next.normal_y = last.ny;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/spc_chk.sv =====
module spc_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input spc_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spc_pkg::rsp_t rsp
);

  // A stalled result keeps its place and its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // A miss carries no normal and no depth.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> rsp.normal_x == 16'sd0 && rsp.normal_y == 16'sd0 &&
    rsp.penetration == '0)
    else $error("miss with nonzero fields");

  // Normal components stay within one in Q1.14.
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.normal_x <= 16'sd16384 && rsp.normal_x >= -16'sd16384 &&
    rsp.normal_y <= 16'sd16384 && rsp.normal_y >= -16'sd16384)
    else $error("normal out of range");

  // With the output register empty, new requests are always taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with empty output");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result present after reset");

endmodule

bind shape_pair_contact_top spc_chk u_chk (.*);

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Full scale of a unit normal component in Q1.14.
  localparam logic signed [15:0] UNIT = 16'sd16384;
  localparam logic [21:0] PEN_SAT = 22'h3FFFFF;
  // Cycles without any accepted request or result before the run is abandoned.
  localparam int STALL_LIMIT = 20000;
  // Pipeline depth taken from the block header, with some margin.
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  spc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  spc_pkg::rsp_t rsp;

  shape_pair_contact_top u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Contacts that are still in flight, oldest first.
  spc_pkg::rsp_t pending_contacts[$];
  int errors = 0;
  int idle_cycles = 0;

  // Idling control: percentages of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // While set, the receiver refuses every result; the sender keeps going.
  bit recv_hold = 0;

  // ---------------------------------------------------------------------------
  // Contact predictor. All geometry is done in Q.9 so that half sizes are the
  // full sizes read directly and positions are simply doubled.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [21:0] pen_clip(longint unsigned v);
    return (v > PEN_SAT) ? PEN_SAT : v[21:0];
  endfunction

  function automatic logic signed [15:0] unit_part(longint signed dv, longint unsigned d);
    longint unsigned u, q;
    if (d == 0) return '0;
    u = (dv < 0) ? -dv : dv;
    q = ((u << 22) + (d >> 1)) / d;
    if (q > UNIT) q = UNIT;
    return (dv < 0) ? -16'(q) : 16'(q);
  endfunction

  // Round contact of a point offset (dx, dy) against a radius r, all in Q.9.
  function automatic spc_pkg::rsp_t round_hit(longint signed dx, longint signed dy,
                                              longint unsigned r);
    spc_pkg::rsp_t c;
    longint unsigned ux, uy, d2, d;
    c = '0;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    d2 = ux * ux + uy * uy;
    if (d2 > r * r) return c;
    c.hit = 1'b1;
    if (d2 == 0) begin
      // Coincident centers: no direction to report.
      c.penetration = pen_clip((r + 1) >> 1);
      return c;
    end
    d = root_floor(d2 << 16);
    c.penetration = pen_clip(((r << 8) - d + 256) >> 9);
    c.normal_x = unit_part(dx, d);
    c.normal_y = unit_part(dy, d);
    return c;
  endfunction

  function automatic spc_pkg::rsp_t predict_contact(spc_pkg::req_t r);
    spc_pkg::rsp_t c;
    longint signed px, py, qx, qy, xmin, xmax, ymin, ymax, cx, cy, xo, yo, dxa, dya;
    longint signed ov[4];
    int best;
    c = '0;
    px = 2 * longint'(r.ax);
    py = 2 * longint'(r.ay);
    qx = 2 * longint'(r.bx);
    qy = 2 * longint'(r.by);
    case (r.kind)
      spc_pkg::KIND_CC: begin
        c = round_hit(qx - px, qy - py,
                      2 * (longint'(r.a_radius) + longint'(r.b_radius)));
      end
      spc_pkg::KIND_CB: begin
        xmin = qx - r.b_width;
        xmax = qx + r.b_width;
        ymin = qy - r.b_height;
        ymax = qy + r.b_height;
        cx = (px < xmin) ? xmin : ((px > xmax) ? xmax : px);
        cy = (py < ymin) ? ymin : ((py > ymax) ? ymax : py);
        if (cx == px && cy == py) begin
          // Circle center inside the box: push out through the nearest face,
          // with ties resolved in the order left, right, bottom, top.
          ov[0] = px - xmin;
          ov[1] = xmax - px;
          ov[2] = py - ymin;
          ov[3] = ymax - py;
          best = 0;
          for (int i = 1; i < 4; i++)
            if (ov[i] < ov[best]) best = i;
          c.hit = 1'b1;
          case (best)
            0: c.normal_x = UNIT;
            1: c.normal_x = -UNIT;
            2: c.normal_y = UNIT;
            default: c.normal_y = -UNIT;
          endcase
          c.penetration = pen_clip((ov[best] + 2 * longint'(r.a_radius) + 1) >> 1);
        end else begin
          c = round_hit(cx - px, cy - py, 2 * longint'(r.a_radius));
        end
      end
      spc_pkg::KIND_BB: begin
        dxa = px - qx;
        dya = py - qy;
        if (dxa < 0) dxa = -dxa;
        if (dya < 0) dya = -dya;
        xo = longint'(r.a_width) + longint'(r.b_width) - dxa;
        yo = longint'(r.a_height) + longint'(r.b_height) - dya;
        if (xo >= 0 && yo >= 0) begin
          c.hit = 1'b1;
          if (xo < yo) begin
            c.penetration = pen_clip((xo + 1) >> 1);
            c.normal_x = (px < qx) ? UNIT : -UNIT;
          end else begin
            c.penetration = pen_clip((yo + 1) >> 1);
            c.normal_y = (py < qy) ? UNIT : -UNIT;
          end
        end
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Inputs change on the falling edge; a request is accepted
  // at the rising edge where valid and ready are both high. Valid stays up
  // between back-to-back requests and drops only for an idle gap or after the last one.
  // ---------------------------------------------------------------------------
  task automatic send_request(spc_pkg::req_t r);
    // Optional idle gap before offering the request.
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_contacts.push_back(predict_contact(r));
    @(negedge clk);
  endtask

  // Receiver ready: redrawn on each falling edge.
  always @(negedge clk) begin
    if (rst || recv_hold)
      rsp_ready <= 1'b0;
    else
      rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Result checker and watchdog, both working from the rising edge.
  always @(posedge clk) begin
    spc_pkg::rsp_t want;
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d contacts outstanding", $time,
                 pending_contacts.size());
        $display("== FAIL ==");
        $finish;
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_contacts.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp);
          errors = errors + 1;
        end else begin
          want = pending_contacts.pop_front();
          if (rsp.hit !== want.hit || rsp.normal_x !== want.normal_x ||
              rsp.normal_y !== want.normal_y || rsp.penetration !== want.penetration) begin
            $display("%0t: mismatch expected hit=%0d n=(%0d,%0d) pen=%0d",
                     $time, want.hit, want.normal_x, want.normal_y, want.penetration);
            $display("%0t:          got hit=%0d n=(%0d,%0d) pen=%0d",
                     $time, rsp.hit, rsp.normal_x, rsp.normal_y, rsp.penetration);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic spc_pkg::req_t mk(logic [1:0] k, int axv, int ayv, int ar, int aw,
                                       int ah, int bxv, int byv, int br, int bw, int bh);
    spc_pkg::req_t r;
    r.kind = k;
    r.ax = 24'(axv); r.ay = 24'(ayv);
    r.a_radius = 20'(ar); r.a_width = 20'(aw); r.a_height = 20'(ah);
    r.bx = 24'(bxv); r.by = 24'(byv);
    r.b_radius = 20'(br); r.b_width = 20'(bw); r.b_height = 20'(bh);
    return r;
  endfunction

  // Coordinate near the origin most of the time so shapes actually meet,
  // with full-range values mixed in to exercise every bit.
  function automatic int rand_pos();
    if ($urandom_range(9) == 0) return $signed($urandom_range(24'hFFFFFF, 0) << 8) >>> 8;
    return $signed($urandom_range(8000)) - 4000;
  endfunction

  function automatic int rand_size();
    if ($urandom_range(9) == 0) return $urandom_range(20'hFFFFF);
    return $urandom_range(3000);
  endfunction

  function automatic spc_pkg::req_t rand_request();
    spc_pkg::req_t r;
    r = '0;
    r.kind = ($urandom_range(19) == 0) ? spc_pkg::KIND_NONE : 2'($urandom_range(2));
    r.ax = 24'(rand_pos()); r.ay = 24'(rand_pos());
    r.bx = 24'(rand_pos()); r.by = 24'(rand_pos());
    r.a_radius = 20'(rand_size()); r.a_width = 20'(rand_size());
    r.a_height = 20'(rand_size());
    r.b_radius = 20'(rand_size()); r.b_width = 20'(rand_size());
    r.b_height = 20'(rand_size());
    // Now and then put the centers on top of each other or on a face line.
    case ($urandom_range(7))
      0: begin r.bx = r.ax; r.by = r.ay; end
      1: r.bx = r.ax + (r.b_width >> 1);
      default: ;
    endcase
    return r;
  endfunction

  // Directed table: each row is a request plus, where it is obvious, the
  // result typed in by hand; the rest rely on the predictor alone.
  typedef struct {
    spc_pkg::req_t r;
    bit            fixed;
    spc_pkg::rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(spc_pkg::req_t r, bit fixed = 0, spc_pkg::rsp_t want = '0);
    dir_row_t row;
    row.r = r; row.fixed = fixed; row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic run_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) send_request(rand_request());
  endtask

  initial begin
    spc_pkg::rsp_t w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unused kind gives nothing at all.
    add_row(mk(spc_pkg::KIND_NONE, 100, 100, 50, 50, 50, 100, 100, 50, 50, 50), 1, '0);
    // Coincident circle centers: zero normal, depth is the radius sum.
    w = '0; w.hit = 1; w.penetration = 30;
    add_row(mk(spc_pkg::KIND_CC, 0, 0, 10, 0, 0, 0, 0, 20, 0, 0), 1, w);
    // Circles touching exactly along x.
    w = '0; w.hit = 1; w.normal_x = UNIT;
    add_row(mk(spc_pkg::KIND_CC, 0, 0, 256, 0, 0, 512, 0, 256, 0, 0), 1, w);
    // Circles just apart.
    add_row(mk(spc_pkg::KIND_CC, 0, 0, 256, 0, 0, 513, 0, 256, 0, 0), 1, '0);
    add_row(mk(spc_pkg::KIND_CC, 0, 0, 300, 0, 0, -200, 150, 100, 0, 0));
    // Zero radii on the same point still touch.
    w = '0; w.hit = 1;
    add_row(mk(spc_pkg::KIND_CC, 5, 5, 0, 0, 0, 5, 5, 0, 0, 0), 1, w);
    // Extreme radii and positions, and the largest possible depth.
    add_row(mk(spc_pkg::KIND_CC, -8388608, -8388608, 20'hFFFFF, 0, 0, 8388607, 8388607,
               20'hFFFFF, 0, 0));
    w = '0; w.hit = 1; w.penetration = 22'd2097150;
    add_row(mk(spc_pkg::KIND_CC, 0, 0, 20'hFFFFF, 0, 0, 0, 0, 20'hFFFFF, 0, 0), 1, w);
    // Circle inside box, nearest face left, right, bottom, top, and a tie.
    add_row(mk(spc_pkg::KIND_CB, -90, 0, 4, 0, 0, 0, 0, 0, 200, 200));
    add_row(mk(spc_pkg::KIND_CB, 90, 0, 4, 0, 0, 0, 0, 0, 200, 200));
    add_row(mk(spc_pkg::KIND_CB, 0, -90, 4, 0, 0, 0, 0, 0, 200, 200));
    add_row(mk(spc_pkg::KIND_CB, 0, 90, 4, 0, 0, 0, 0, 0, 200, 200));
    add_row(mk(spc_pkg::KIND_CB, 0, 0, 4, 0, 0, 0, 0, 0, 200, 200));
    // Circle center on the box edge, and outside near a corner.
    add_row(mk(spc_pkg::KIND_CB, 100, 0, 10, 0, 0, 0, 0, 0, 200, 100));
    add_row(mk(spc_pkg::KIND_CB, 110, 60, 20, 0, 0, 0, 0, 0, 200, 100));
    add_row(mk(spc_pkg::KIND_CB, 300, 300, 20, 0, 0, 0, 0, 0, 200, 100), 1, '0);
    add_row(mk(spc_pkg::KIND_CB, 8388607, -8388608, 20'hFFFFF, 0, 0, -8388608, 8388607, 0,
               20'hFFFFF, 20'hFFFFF));
    // Box-box along x, along y, touching edges, tie going to y, apart.
    add_row(mk(spc_pkg::KIND_BB, 0, 0, 0, 100, 100, 150, 10, 0, 100, 100));
    add_row(mk(spc_pkg::KIND_BB, 0, 0, 0, 100, 100, 10, -150, 0, 100, 100));
    w = '0; w.hit = 1; w.normal_x = UNIT;
    add_row(mk(spc_pkg::KIND_BB, 0, 0, 0, 100, 400, 100, 0, 0, 100, 400), 1, w);
    add_row(mk(spc_pkg::KIND_BB, 0, 0, 0, 100, 100, 0, 0, 0, 100, 100));
    add_row(mk(spc_pkg::KIND_BB, 0, 0, 0, 100, 100, 500, 0, 0, 100, 100), 1, '0);
    add_row(mk(spc_pkg::KIND_BB, 0, 0, 0, 20'hFFFFF, 20'hFFFFF, 0, 0, 0, 20'hFFFFF,
               20'hFFFFF));

    recv_stall_pct = 0;
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].r);
      // A hand-typed result overrides the prediction; any disagreement
      // between the two is a predictor bug and is reported as such.
      if (dir_rows[i].fixed) begin
        if (pending_contacts[$] !== dir_rows[i].want) begin
          $display("%0t: mismatch expected %p got prediction %p", $time,
                   dir_rows[i].want, pending_contacts[$]);
          errors = errors + 1;
        end
        pending_contacts[$] = dir_rows[i].want;
      end
    end

    run_phase(150, 0, 0);
    run_phase(120, 61, 0);
    run_phase(120, 0, 61);
    run_phase(120, 61, 61);
    // Long receiver hold: the pipeline fills and backpressures the input.
    fork
      begin
        recv_hold = 1;
        repeat (200) @(posedge clk);
        recv_hold = 0;
      end
      run_phase(100, 0, 0);
    join
    run_phase(40, 19, 19);
    req_valid <= 1'b0;

    recv_stall_pct = 0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
